[hdl/prun_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prun_pkg
// Shared types and constants of the page run allocator: table geometry, item
// and result beats, table access bundle and sequencer states.
// ----------------------------------------------------------------------------
package prun_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int LEN_W       = 7;
	localparam int LUT_W       = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LUT_BASE   = 1'd1;

	// boundary tag as held in the run table
	typedef struct packed {
		logic             free;
		logic [LEN_W-1:0] len;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic       kind;
		logic [6:0] run_length;
		logic [5:0] page_index;
	} item_t;

	typedef struct packed {
		logic             granted;
		logic [LUT_W-1:0] lut_number;
		logic [5:0]       start_index;
	} result_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} tbl_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_NEXT,
		ST_CHKP,
		ST_PREV,
		ST_MERGE,
		ST_WR_AH,
		ST_WR_AT,
		ST_WR_BH,
		ST_WR_BT
	} state_t;

endpackage

[hdl/prun_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prun_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module prun_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/prun_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prun_table
// Run table storage: boundary tag RAM plus per-entry valid bits. An entry
// 0 or count-1 unwritten since the last reinit reads as the initial free run.
// ----------------------------------------------------------------------------
module prun_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic [prun_pkg::CNT_W-1:0] count,
	input  prun_pkg::tbl_req_t        req,
	output prun_pkg::entry_t          rd_ent
);
	import prun_pkg::*;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   vld_s1;
	logic                   dflt_s1;
	logic [ENTRY_W-1:0]     ram_dout;
	logic [CNT_W-1:0]       cnt_m1;
	entry_t                 dflt_ent;

	prun_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.wr_addr),
		.wdata (req.wr_data),
		.re    (req.rd_en),
		.raddr (req.rd_addr),
		.rdata (ram_dout)
	);

	assign cnt_m1 = count - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// side info travels with the RAM read so it lines up with the data
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			vld_s1  <= valid_q[req.rd_addr];
			dflt_s1 <= (req.rd_addr == '0) || ({1'b0, req.rd_addr} == cnt_m1);
		end
	end

	always_comb begin
		dflt_ent.free = 1'b1;
		dflt_ent.len  = LEN_W'(count);
		if (vld_s1) begin
			rd_ent = entry_t'(ram_dout);
		end else if (dflt_s1) begin
			rd_ent = dflt_ent;
		end else begin
			rd_ent = '0;
		end
	end

endmodule

[hdl/prun_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prun_ctrl
// Sequencer: walks run heads one per cycle, checks neighbours on free, then
// writes the new boundary tags back and issues the result beat.
// ----------------------------------------------------------------------------
module prun_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  prun_pkg::item_t            item,
	input  logic [prun_pkg::CNT_W-1:0] count,
	input  logic [prun_pkg::LUT_W-1:0] lut_base,
	input  prun_pkg::entry_t           rd_ent,
	output prun_pkg::tbl_req_t         tbl_req,
	output logic                       busy,
	output logic                       done,
	output prun_pkg::result_t          result
);
	import prun_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] h_q, h_d;
	logic             kind_q, kind_d;
	logic [6:0]       req_q, req_d;
	logic [5:0]       idx_q, idx_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [8:0]       flen_q, flen_d;
	logic [IDX_W-1:0] a_head_q, a_head_d;
	logic [LEN_W-1:0] a_len_q, a_len_d;
	logic             a_free_q, a_free_d;
	logic             split_q, split_d;
	logic [IDX_W-1:0] start_q, start_d;
	logic             done_q, done_d;
	result_t          result_q, result_d;

	logic             accept;
	logic [LEN_W-1:0] step;
	logic [7:0]       nh;
	logic             fit;
	logic [8:0]       run_end;
	logic [LEN_W-1:0] a_tail_off;
	logic [LEN_W-1:0] b_tail_off;
	logic             fin;
	logic             fin_ok;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	assign step       = (rd_ent.len == '0) ? LEN_W'(1) : rd_ent.len;
	assign nh         = {2'b0, h_q} + {1'b0, step};
	assign fit        = rd_ent.free && (rd_ent.len >= req_q)
		&& (({2'b0, h_q} + {1'b0, rd_ent.len}) <= {1'b0, count});
	assign run_end    = {3'b0, head_q} + flen_q;
	assign a_tail_off = {1'b0, a_head_q} + a_len_q - LEN_W'(1);
	assign b_tail_off = {1'b0, start_q} + req_q - LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		h_q      <= h_d;
		kind_q   <= kind_d;
		req_q    <= req_d;
		idx_q    <= idx_d;
		head_q   <= head_d;
		flen_q   <= flen_d;
		a_head_q <= a_head_d;
		a_len_q  <= a_len_d;
		a_free_q <= a_free_d;
		split_q  <= split_d;
		start_q  <= start_d;
		result_q <= result_d;
	end

	always_comb begin
		state_d  = state_q;
		h_d      = h_q;
		kind_d   = kind_q;
		req_d    = req_q;
		idx_d    = idx_q;
		head_d   = head_q;
		flen_d   = flen_q;
		a_head_d = a_head_q;
		a_len_d  = a_len_q;
		a_free_d = a_free_q;
		split_d  = split_q;
		start_d  = start_q;
		result_d = result_q;
		done_d   = 1'b0;
		tbl_req  = '0;
		fin      = 1'b0;
		fin_ok   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_d = item.kind;
					req_d  = item.run_length;
					idx_d  = item.page_index;
					if (item.kind == KIND_ALLOC && item.run_length == '0) begin
						fin = 1'b1;
					end else begin
						tbl_req.rd_en   = 1'b1;
						tbl_req.rd_addr = '0;
						h_d             = '0;
						state_d         = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (kind_q == KIND_ALLOC && fit) begin
					start_d = h_q;
					if (rd_ent.len == req_q) begin
						a_head_d = h_q;
						a_len_d  = rd_ent.len;
						a_free_d = 1'b0;
						split_d  = 1'b0;
					end else begin
						// free remainder first, allocated front afterwards
						a_head_d = h_q + req_q[IDX_W-1:0];
						a_len_d  = rd_ent.len - req_q;
						a_free_d = 1'b1;
						split_d  = 1'b1;
					end
					state_d = ST_WR_AH;
				end else if (kind_q == KIND_FREE && {1'b0, h_q} == {1'b0, idx_q}) begin
					if (!rd_ent.free) begin
						head_d = h_q;
						flen_d = {2'b0, step};
						if (nh < {1'b0, count}) begin
							tbl_req.rd_en   = 1'b1;
							tbl_req.rd_addr = nh[IDX_W-1:0];
							state_d         = ST_NEXT;
						end else begin
							state_d = ST_CHKP;
						end
					end else begin
						fin = 1'b1;
					end
				end else if (nh >= {1'b0, count}) begin
					fin = 1'b1;
				end else begin
					tbl_req.rd_en   = 1'b1;
					tbl_req.rd_addr = nh[IDX_W-1:0];
					h_d             = nh[IDX_W-1:0];
				end
			end
			ST_NEXT: begin
				if (rd_ent.free) begin
					flen_d = flen_q + {2'b0, step};
				end
				state_d = ST_CHKP;
			end
			ST_CHKP: begin
				if (head_q != '0) begin
					tbl_req.rd_en   = 1'b1;
					tbl_req.rd_addr = head_q - IDX_W'(1);
					state_d         = ST_PREV;
				end else begin
					state_d = ST_MERGE;
				end
			end
			ST_PREV: begin
				// preceding run only merged if its length fits before the head
				if (rd_ent.free && (step <= {1'b0, head_q})) begin
					head_d = head_q - step[IDX_W-1:0];
					flen_d = flen_q + {2'b0, step};
				end
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				a_head_d = head_q;
				a_free_d = 1'b1;
				split_d  = 1'b0;
				start_d  = idx_q;
				if (run_end > {2'b0, count}) begin
					a_len_d = count - {1'b0, head_q};
				end else begin
					a_len_d = flen_q[LEN_W-1:0];
				end
				state_d = ST_WR_AH;
			end
			ST_WR_AH: begin
				tbl_req.wr_en        = 1'b1;
				tbl_req.wr_addr      = a_head_q;
				tbl_req.wr_data.free = a_free_q;
				tbl_req.wr_data.len  = a_len_q;
				state_d              = ST_WR_AT;
			end
			ST_WR_AT: begin
				tbl_req.wr_en        = 1'b1;
				tbl_req.wr_addr      = a_tail_off[IDX_W-1:0];
				tbl_req.wr_data.free = a_free_q;
				tbl_req.wr_data.len  = a_len_q;
				if (split_q) begin
					state_d = ST_WR_BH;
				end else begin
					fin    = 1'b1;
					fin_ok = 1'b1;
				end
			end
			ST_WR_BH: begin
				tbl_req.wr_en        = 1'b1;
				tbl_req.wr_addr      = start_q;
				tbl_req.wr_data.free = 1'b0;
				tbl_req.wr_data.len  = req_q;
				state_d              = ST_WR_BT;
			end
			ST_WR_BT: begin
				tbl_req.wr_en        = 1'b1;
				tbl_req.wr_addr      = b_tail_off[IDX_W-1:0];
				tbl_req.wr_data.free = 1'b0;
				tbl_req.wr_data.len  = req_q;
				fin                  = 1'b1;
				fin_ok               = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (fin) begin
			state_d = ST_IDLE;
			done_d  = 1'b1;
			if (fin_ok) begin
				result_d.granted     = 1'b1;
				result_d.lut_number  = lut_base + {{(LUT_W-IDX_W){1'b0}}, start_q};
				result_d.start_index = start_q;
			end else begin
				result_d = '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_req.wr_en |-> !tbl_req.rd_en)
		else $error("table read and write in the same cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result beat while sequencer still busy");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> {1'b0, h_q} < count)
		else $error("walk pointer beyond pages in use");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_req.wr_en |-> {1'b0, tbl_req.wr_addr} < count)
		else $error("tag write beyond pages in use");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !result_q.granted |-> result_q.lut_number == '0
			&& result_q.start_index == '0)
		else $error("refused beat carries non-zero fields");
`endif

endmodule

[hdl/page_run_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_run_allocator
// First-fit allocator of contiguous page runs kept with boundary tags.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy low; its result beat shows
// on result with done high for exactly one cycle and cannot be held off.
// Timing is set by the run walk through the tag RAM, one run head a cycle.
// An allocate walks to the first fitting run, visiting at most 64 run heads,
// then writes its head and tail tags, for a split those of the free remainder
// and then of the allocated front. A zero-length request answers in the
// cycle after start with busy staying low. A free walks to its head, then
// checks its neighbours and writes the merged tags; a refused free answers
// as soon as the walk decides. Writing page_count reinitialises the table at
// once, with no clearing pass.
module page_run_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  prun_pkg::item_t                 item,
	output logic                            done,
	output prun_pkg::result_t               result,
	input  logic                            cfg_we,
	input  logic [prun_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prun_pkg::CFG_DATA_W-1:0] cfg_data
);
	import prun_pkg::*;

	logic [6:0]       page_count_q;
	logic [LUT_W-1:0] lut_base_q;
	logic [CNT_W-1:0] count;
	logic             tbl_clear;
	tbl_req_t         tbl_req;
	entry_t           rd_ent;

	assign tbl_clear = cfg_we && (cfg_index == CFG_PAGE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= 7'(TABLE_DEPTH);
			lut_base_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAGE_COUNT: page_count_q <= cfg_data[6:0];
				CFG_LUT_BASE:   lut_base_q   <= cfg_data[LUT_W-1:0];
				default: ;
			endcase
		end
	end

	// pages in use, with zero taken as one and the top clipped to the table
	always_comb begin
		if (page_count_q == '0) begin
			count = CNT_W'(1);
		end else if ({1'b0, page_count_q} > 8'(TABLE_DEPTH)) begin
			count = CNT_W'(TABLE_DEPTH);
		end else begin
			count = CNT_W'(page_count_q);
		end
	end

	prun_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (tbl_clear),
		.count  (count),
		.req    (tbl_req),
		.rd_ent (rd_ent)
	);

	prun_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.count    (count),
		.lut_base (lut_base_q),
		.rd_ent   (rd_ent),
		.tbl_req  (tbl_req),
		.busy     (busy),
		.done     (done),
		.result   (result)
	);

endmodule
